### sv/dis_pkg.sv
// ----------------------------------------------------------------------------
// dis_pkg
// Shared types for the digit insertion sorter: digit type and cell controls.
// ----------------------------------------------------------------------------
package dis_pkg;

    localparam int unsigned DIGIT_W = 4;

    typedef logic [DIGIT_W-1:0] t_digit;

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic   insert;    // place ins_digit into the sorted row
        logic   shift;     // move every cell one place toward the output
        t_digit ins_digit; // digit being inserted
    } t_cell_ctl;

endpackage

### sv/dis_cell.sv
// ----------------------------------------------------------------------------
// dis_cell
// One cell of the sorted row: holds a digit and its valid bit, compares it
// with the incoming digit and takes its neighbor's value on a move.
// ----------------------------------------------------------------------------
module dis_cell import dis_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_digit    i_prev_digit,
    input  logic      i_prev_valid,
    input  logic      i_prev_less,
    input  t_digit    i_next_digit,
    input  logic      i_next_valid,
    output t_digit    o_digit,
    output logic      o_valid,
    output logic      o_less
);

    t_digit r_digit;
    logic   r_valid;
    t_digit n_digit;
    logic   n_valid;

    // held digit is strictly smaller than the one coming in
    assign o_less = r_valid && (r_digit < i_ctl.ins_digit);

    always_comb begin
        n_digit = r_digit;
        n_valid = r_valid;
        if (i_ctl.insert) begin
            if (o_less) begin
                n_digit = r_digit;
                n_valid = r_valid;
            end else if (i_prev_less) begin
                n_digit = i_ctl.ins_digit;
                n_valid = 1'b1;
            end else begin
                // larger digits move up one place
                n_digit = i_prev_digit;
                n_valid = i_prev_valid;
            end
        end else if (i_ctl.shift) begin
            n_digit = i_next_digit;
            n_valid = i_next_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_digit = r_digit;
    assign o_valid = r_valid;

endmodule

### sv/digit_insertion_sorter.sv
// ----------------------------------------------------------------------------
// digit_insertion_sorter
// Insertion sort of one number's digits in a row of compare-and-move cells.
// ----------------------------------------------------------------------------
// Each accepted digit is placed in its sorted position: every cell compares
// its digit with the new one and either keeps it, takes the new digit, or
// takes its lower neighbor's digit. A digit arriving with DEPTH cells full
// is dropped and sets the overflow flag. A digit carrying the end mark is
// inserted (or dropped, if the row is full) and then the row drains through
// cell 0, one digit per cycle while the output is ready, smallest first; no
// input item is accepted until the number's final digit has left.
module digit_insertion_sorter import dis_pkg::*; #(
    parameter int unsigned DEPTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_digit i_digit,
    input  logic   i_end_of_number,
    output logic   o_valid,
    input  logic   i_ready,
    output t_digit o_sorted_digit,
    output logic   o_last_out,
    output logic   o_overflowed
);

    t_digit     w_digit [DEPTH];
    logic [DEPTH-1:0] w_valid;
    logic [DEPTH-1:0] w_less;
    t_cell_ctl  w_ctl;

    logic r_emit;
    logic n_emit;
    logic r_dropped;
    logic n_dropped;

    logic w_in_acc;
    logic w_out_acc;
    logic w_full;

    assign w_full    = w_valid[DEPTH-1];
    assign o_ready   = !r_emit;
    assign w_in_acc  = i_valid && o_ready;
    assign o_valid   = r_emit;
    assign w_out_acc = o_valid && i_ready;

    assign w_ctl.insert    = w_in_acc && !w_full;
    assign w_ctl.shift     = w_out_acc;
    assign w_ctl.ins_digit = i_digit;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_digit w_pd;
            logic   w_pv;
            logic   w_pl;
            t_digit w_nd;
            logic   w_nv;
            if (g == 0) begin : g_first
                assign w_pd = '0;
                assign w_pv = 1'b0;
                assign w_pl = 1'b1;
            end else begin : g_mid
                assign w_pd = w_digit[g-1];
                assign w_pv = w_valid[g-1];
                assign w_pl = w_less[g-1];
            end
            if (g == DEPTH-1) begin : g_last
                assign w_nd = '0;
                assign w_nv = 1'b0;
            end else begin : g_body
                assign w_nd = w_digit[g+1];
                assign w_nv = w_valid[g+1];
            end
            dis_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_ctl        (w_ctl),
                .i_prev_digit (w_pd),
                .i_prev_valid (w_pv),
                .i_prev_less  (w_pl),
                .i_next_digit (w_nd),
                .i_next_valid (w_nv),
                .o_digit      (w_digit[g]),
                .o_valid      (w_valid[g]),
                .o_less       (w_less[g])
            );
        end
    endgenerate

    assign o_sorted_digit = w_digit[0];
    assign o_last_out     = !w_valid[1];
    assign o_overflowed   = r_dropped;

    always_comb begin
        n_emit    = r_emit;
        n_dropped = r_dropped;
        if (w_in_acc) begin
            if (w_full) begin
                n_dropped = 1'b1;
            end
            if (i_end_of_number) begin
                n_emit = 1'b1;
            end
        end
        if (w_out_acc && o_last_out) begin
            n_emit    = 1'b0;
            n_dropped = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit    <= 1'b0;
            r_dropped <= 1'b0;
        end else begin
            r_emit    <= n_emit;
            r_dropped <= n_dropped;
        end
    end

    a_emit_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> w_valid[0])
        else $error("emitting with an empty row");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !w_full) |=>
            ($countones(w_valid) == $past($countones(w_valid)) + 1))
        else $error("insert did not add one cell");

    a_last_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last_out) |=> (!r_emit && (w_valid == '0) && !r_dropped))
        else $error("row not empty after last item");

    a_drop_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && w_full) |=> r_dropped)
        else $error("dropped digit did not raise overflow");

endmodule

### sim/digit_insertion_sorter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digit_insertion_sorter_test
// Self-checking bench for the digit insertion sorter: a short directed table,
// then random numbers of random length, under several idle and stall mixes.
// Results are checked against a behavioral insertion sort or the typed table row.
// ----------------------------------------------------------------------------
module digit_insertion_sorter_test;
    import dis_pkg::*;

    localparam int DEPTH       = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int STUCK_LIMIT = 2000;
    localparam int PHASE_ITEMS = 105;

    typedef struct packed {
        t_digit digit;
        logic   last;
        logic   ovf;
    } t_sorted;

    typedef struct packed {
        t_digit  digit;
        logic    eon;
        logic    typed;  // result written out below instead of predicted
        t_sorted want;
    } t_row;

    localparam t_sorted NO_CHECK = '0;
    localparam int      N_ROWS   = 24;

    localparam t_row DIRECTED [N_ROWS] = '{
        // lone digits right after reset: smallest and largest 4-bit value
        '{4'd0,  1'b1, 1'b1, '{4'd0,  1'b1, 1'b0}},
        '{4'd15, 1'b1, 1'b1, '{4'd15, 1'b1, 1'b0}},
        // unsorted, equal digits, one above nine
        '{4'd9,  1'b0, 1'b0, NO_CHECK},
        '{4'd3,  1'b0, 1'b0, NO_CHECK},
        '{4'd3,  1'b0, 1'b0, NO_CHECK},
        '{4'd12, 1'b0, 1'b0, NO_CHECK},
        '{4'd7,  1'b1, 1'b0, NO_CHECK},
        // descending fill, every digit lands in front
        '{4'd15, 1'b0, 1'b0, NO_CHECK},
        '{4'd14, 1'b0, 1'b0, NO_CHECK},
        '{4'd13, 1'b0, 1'b0, NO_CHECK},
        '{4'd12, 1'b0, 1'b0, NO_CHECK},
        '{4'd11, 1'b0, 1'b0, NO_CHECK},
        '{4'd10, 1'b0, 1'b0, NO_CHECK},
        '{4'd9,  1'b0, 1'b0, NO_CHECK},
        '{4'd8,  1'b0, 1'b0, NO_CHECK},
        '{4'd7,  1'b0, 1'b0, NO_CHECK},
        '{4'd6,  1'b0, 1'b0, NO_CHECK},
        '{4'd5,  1'b0, 1'b0, NO_CHECK},
        '{4'd4,  1'b0, 1'b0, NO_CHECK},
        '{4'd3,  1'b0, 1'b0, NO_CHECK},
        '{4'd2,  1'b0, 1'b0, NO_CHECK},
        '{4'd1,  1'b0, 1'b0, NO_CHECK},
        '{4'd0,  1'b0, 1'b0, NO_CHECK},
        // store full: end digit dropped, run still drains with overflow set
        '{4'd5,  1'b1, 1'b0, NO_CHECK}
    };

    logic   i_clk           = 1'b0;
    logic   i_rst_n         = 1'b0;
    logic   i_valid         = 1'b0;
    logic   o_ready;
    t_digit i_digit         = '0;
    logic   i_end_of_number = 1'b0;
    logic   o_valid;
    logic   i_ready         = 1'b0;
    t_digit o_sorted_digit;
    logic   o_last_out;
    logic   o_overflowed;

    digit_insertion_sorter #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_digit        (i_digit),
        .i_end_of_number(i_end_of_number),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_sorted_digit (o_sorted_digit),
        .o_last_out     (o_last_out),
        .o_overflowed   (o_overflowed)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // sorted store of the number being collected
    t_digit  held_digits [DEPTH];
    int      held_count    = 0;
    logic    digit_dropped = 1'b0;
    t_sorted run_out [DEPTH];

    t_sorted sorted_expected [$];
    t_sorted want;
    int      failures      = 0;
    int      items_sent    = 0;
    int      send_idle_pct = 0;
    int      recv_stall_pct = 0;
    int      hold_req_cnt  = 0;
    int      hold_ack_cnt  = 0;
    int      hold_left     = 0;
    int      stuck_cycles  = 0;

    // inserts one digit; on the end mark fills run_out and returns its length
    function automatic int take_digit(input t_digit d, input logic eon);
        int pos;
        int k;
        int n;
        pos = 0;
        n   = 0;
        if (held_count >= DEPTH) begin
            digit_dropped = 1'b1;
        end else begin
            while (pos < held_count && held_digits[pos] < d) pos++;
            for (k = held_count; k > pos; k--) held_digits[k] = held_digits[k-1];
            held_digits[pos] = d;
            held_count++;
        end
        if (eon) begin
            n = held_count;
            for (k = 0; k < n; k++) begin
                run_out[k] = '{held_digits[k], (k == n - 1), digit_dropped};
            end
            held_count    = 0;
            digit_dropped = 1'b0;
        end
        return n;
    endfunction

    task automatic report_mismatch(input string msg);
        failures++;
        $display("%0t ns: %s", $time, msg);
    endtask

    task automatic offer_item(input t_digit d, input logic eon, input logic typed,
                              input t_sorted typed_want);
        int n;
        int k;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_digit         <= d;
        i_end_of_number <= eon;
        // decide acceptance on settled values, at the falling edge before the clock edge
        do @(negedge i_clk); while (!o_ready);
        n = take_digit(d, eon);
        if (typed) begin
            sorted_expected.push_back(typed_want);
        end else begin
            for (k = 0; k < n; k++) sorted_expected.push_back(run_out[k]);
        end
        items_sent++;
        @(posedge i_clk);
    endtask

    task automatic send_random_number();
        int     len;
        int     pick;
        int     k;
        t_digit d;
        pick = $urandom_range(99);
        if (pick < 10)      len = $urandom_range(DEPTH + 4, DEPTH + 1);
        else if (pick < 20) len = DEPTH;
        else                len = $urandom_range(DEPTH - 1, 1);
        for (k = 1; k <= len; k++) begin
            if ($urandom_range(99) < 85) d = t_digit'($urandom_range(9));
            else                         d = t_digit'($urandom_range(15, 10));
            offer_item(d, k == len, 1'b0, NO_CHECK);
        end
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sorted_expected.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input logic hold);
        int start;
        send_idle_pct  = idle_pct;
        recv_stall_pct <= stall_pct;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) begin
            // long receiver hold-off while numbers keep coming
            if (hold && items_sent - start >= PHASE_ITEMS / 3 && hold_req_cnt == 0) begin
                hold_req_cnt <= hold_req_cnt + 1;
            end
            send_random_number();
        end
    endtask

    // receiver: random stalls, plus the requested hold-off
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt <= hold_req_cnt;
            hold_left    <= HOLD_CYCLES - 1;
            i_ready      <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (sorted_expected.size() == 0) begin
                report_mismatch($sformatf("result with nothing expected: digit %0d",
                                          o_sorted_digit));
            end else begin
                want = sorted_expected.pop_front();
                if (o_sorted_digit !== want.digit)
                    report_mismatch($sformatf("sorted_digit got %0d, want %0d",
                                              o_sorted_digit, want.digit));
                if (o_last_out !== want.last)
                    report_mismatch($sformatf("last_out got %b, want %b",
                                              o_last_out, want.last));
                if (o_overflowed !== want.ovf)
                    report_mismatch($sformatf("overflowed got %b, want %b",
                                              o_overflowed, want.ovf));
            end
        end
    end

    // watchdog on cycles with no item moving on either side
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        int r;
        i_rst_n <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < N_ROWS; r++) begin
            offer_item(DIRECTED[r].digit, DIRECTED[r].eon, DIRECTED[r].typed,
                       DIRECTED[r].want);
        end

        run_phase(0, 0, 1'b1);
        drain_results();
        run_phase(67, 0, 1'b0);
        run_phase(0, 67, 1'b0);
        // sender waits for every result before the mixed phase
        drain_results();
        run_phase(31, 31, 1'b0);

        drain_results();
        repeat (DEPTH + 4) @(posedge i_clk);
        if (failures == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

### filelist.f
sv/dis_pkg.sv
sv/dis_cell.sv
sv/digit_insertion_sorter.sv
sim/digit_insertion_sorter_test.sv
